// File: hw/rtl/lpr_pkg.sv
// Shared types and constants for the line pixel rasterizer.
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CANVAS_BITS    = 12;
    localparam int PIX_BITS       = 11;
    localparam int PIX_LIMIT      = 2048;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = 12'd600;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_HEIGHT = 2'd1;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        MODE_VERT  = 2'd0,
        MODE_XSTEP = 2'd1,
        MODE_YSTEP = 2'd2
    } line_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mul0;
        logic mul1;
        logic sum;
        logic div_init;
        logic div_step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic no_div;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: hw/rtl/lpr_ctrl.sv
// Sequencing state machine for the line pixel rasterizer.
`timescale 1ns / 1ps

module lpr_ctrl
    import lpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                cmd.mul0 = 1'b1;
                // Vertical lines and words without a pixel need no quotient.
                state_next = status.no_div ? ST_OUT : ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/lpr_datapath.sv
// Line state, multiply, divide and output register of the line pixel rasterizer.
`timescale 1ns / 1ps

module lpr_datapath
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((2 * PIX_BITS + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    input  logic [IN_W-1:0]         s_tdata,
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_W-1:0]        m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CANVAS_BITS-1:0]  cfg_data
);

    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int PW   = 2 * DW;
    localparam int NW   = PW + 1;
    localparam int QB   = CB;
    localparam int CNTW = $clog2(QB + 1);
    localparam int CMPW = (CB > CANVAS_BITS) ? CB : CANVAS_BITS;

    // Configuration registers.
    logic [CANVAS_BITS-1:0] canvas_w_reg;
    logic [CANVAS_BITS-1:0] canvas_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_w_reg <= CANVAS_RESET;
            canvas_h_reg <= CANVAS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CANVAS_WIDTH:  canvas_w_reg <= cfg_data;
                CFG_CANVAS_HEIGHT: canvas_h_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input word fields.
    logic signed [CB-1:0] in_sx, in_sy, in_ex, in_ey;
    assign in_sx = s_tdata[CB-1:0];
    assign in_sy = s_tdata[2*CB-1:CB];
    assign in_ex = s_tdata[3*CB-1:2*CB];
    assign in_ey = s_tdata[4*CB-1:3*CB];

    logic signed [DW-1:0] in_run, in_rise;
    logic        [DW-1:0] in_run_mag, in_rise_mag;
    assign in_run      = DW'(in_ex) - DW'(in_sx);
    assign in_rise     = DW'(in_ey) - DW'(in_sy);
    assign in_run_mag  = in_run[DW-1]  ? DW'(-in_run)  : DW'(in_run);
    assign in_rise_mag = in_rise[DW-1] ? DW'(-in_rise) : DW'(in_rise);

    // Line state.
    logic                 line_active_reg;
    logic signed [CB-1:0] ox_reg, oy_reg, tx_reg, ty_reg, step_reg;
    logic signed [DW-1:0] run_reg, rise_reg;
    line_mode_t           mode_reg;
    logic                 down_reg;
    logic                 skip_reg;

    logic signed [CB-1:0] step_next;
    logic signed [CB-1:0] last_coord;
    logic                 step_done;
    assign step_next  = down_reg ? step_reg - 1'b1 : step_reg + 1'b1;
    assign last_coord = (mode_reg == MODE_XSTEP) ? tx_reg : ty_reg;
    assign step_done  = (step_next == last_coord);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            ox_reg          <= '0;
            oy_reg          <= '0;
            tx_reg          <= '0;
            ty_reg          <= '0;
            step_reg        <= '0;
            run_reg         <= '0;
            rise_reg        <= '0;
            mode_reg        <= MODE_VERT;
            down_reg        <= 1'b0;
            skip_reg        <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (s_tuser == CMD_START)
            begin
                ox_reg   <= in_sx;
                oy_reg   <= in_sy;
                tx_reg   <= in_ex;
                ty_reg   <= in_ey;
                run_reg  <= in_run;
                rise_reg <= in_rise;
                if (in_run == '0)
                begin
                    mode_reg        <= MODE_VERT;
                    step_reg        <= in_sy;
                    down_reg        <= (in_sy >= in_ey);
                    // A start on a single point draws nothing.
                    line_active_reg <= (in_rise != '0);
                    skip_reg        <= (in_rise == '0);
                end
                else if (in_rise_mag <= in_run_mag)
                begin
                    mode_reg        <= MODE_XSTEP;
                    step_reg        <= in_sx;
                    down_reg        <= (in_sx > in_ex);
                    line_active_reg <= 1'b1;
                    skip_reg        <= 1'b0;
                end
                else
                begin
                    mode_reg        <= MODE_YSTEP;
                    step_reg        <= in_sy;
                    down_reg        <= (in_sy > in_ey);
                    line_active_reg <= 1'b1;
                    skip_reg        <= 1'b0;
                end
            end
            else
            begin
                skip_reg <= !line_active_reg;
            end
        end
        else if (cmd.emit && !skip_reg)
        begin
            step_reg <= step_next;
            if (step_done)
            begin
                line_active_reg <= 1'b0;
            end
        end
    end

    // Numerator origin*span + slope*(step - origin), built with one multiplier.
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [DW-1:0] d_reg;
    logic signed [PW-1:0] acc_reg, prod_reg;
    logic signed [NW-1:0] num_reg;
    logic signed [DW-1:0] divisor;

    assign divisor = (mode_reg == MODE_XSTEP) ? run_reg : rise_reg;

    always_comb
    begin
        if (cmd.mul0)
        begin
            mul_a = (mode_reg == MODE_XSTEP) ? DW'(oy_reg) : DW'(ox_reg);
            mul_b = divisor;
        end
        else
        begin
            mul_a = (mode_reg == MODE_XSTEP) ? rise_reg : run_reg;
            mul_b = d_reg;
        end
    end
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.mul0)
        begin
            acc_reg <= mul_p;
            d_reg   <= (mode_reg == MODE_XSTEP) ? DW'(step_reg) - DW'(ox_reg)
                                                : DW'(step_reg) - DW'(oy_reg);
        end
        if (cmd.mul1)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.sum)
        begin
            num_reg <= NW'(acc_reg) + NW'(prod_reg);
        end
    end

    // Restoring divider on magnitudes, one quotient bit per cycle.
    logic [NW-1:0]   rem_reg;
    logic [NW-1:0]   dsh_reg;
    logic [QB-1:0]   q_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            neg_reg;
    logic [DW-1:0]   div_mag;

    assign div_mag = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
            dsh_reg <= NW'(div_mag) << (QB - 1);
            neg_reg <= num_reg[NW-1] ^ divisor[DW-1];
            q_reg   <= '0;
            cnt_reg <= CNTW'(QB);
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[QB-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[QB-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Pixel selection and canvas check.
    logic signed [DW-1:0] quo;
    logic signed [DW-1:0] px, py;
    logic        [CMPW-1:0] px_c, py_c;
    logic                 pix_ok;

    assign quo = neg_reg ? DW'(-{1'b0, q_reg}) : DW'({1'b0, q_reg});

    always_comb
    begin
        unique case (mode_reg)
            MODE_XSTEP:
            begin
                px = DW'(step_reg);
                py = quo;
            end
            MODE_YSTEP:
            begin
                px = quo;
                py = DW'(step_reg);
            end
            default:
            begin
                px = DW'(ox_reg);
                py = DW'(step_reg);
            end
        endcase
    end

    assign px_c   = CMPW'(px[CB-1:0]);
    assign py_c   = CMPW'(py[CB-1:0]);
    assign pix_ok = !skip_reg && !px[DW-1] && !py[DW-1]
                    && (px_c < CMPW'(canvas_w_reg)) && (py_c < CMPW'(canvas_h_reg))
                    && (px_c < CMPW'(PIX_LIMIT)) && (py_c < CMPW'(PIX_LIMIT));

    // Output register.
    logic                m_tvalid_reg;
    logic [PIX_BITS-1:0] pix_x_reg, pix_y_reg;
    logic                pix_valid_reg;
    logic                done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pix_x_reg     <= pix_ok ? PIX_BITS'(px_c) : '0;
            pix_y_reg     <= pix_ok ? PIX_BITS'(py_c) : '0;
            pix_valid_reg <= pix_ok;
            done_reg      <= skip_reg || step_done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({pix_y_reg, pix_x_reg});
    assign m_tuser  = pix_valid_reg;
    assign m_tlast  = done_reg;

    assign status.no_div   = skip_reg || (mode_reg == MODE_VERT);
    assign status.div_last = (cnt_reg == CNTW'(1));
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule

// File: hw/rtl/line_pixel_rasterizer_unit.sv
// Top level of the line pixel rasterizer: controller plus datapath.
//
//  Channel  Direction  Payload
//  s_*      in         tuser: command; tdata: start_x, start_y, end_x, end_y
//  m_*      out        tdata: pixel_x, pixel_y; tuser: pixel_valid; tlast: line_done
//  cfg_*    in         cfg_index (0 canvas_width, 1 canvas_height), cfg_data
//
// A word that draws a sloped pixel steps through MUL0, MUL1, SUM, DIV_INIT, DIV and OUT;
// the restoring divider yields one quotient bit per cycle. Vertical lines, advances
// while idle and single-point starts go from MUL0 straight to OUT. Reset clears the
// line state and loads both canvas registers with 600. The next input word is taken
// while a result still waits in the output register; a stalled output holds the
// controller before the second result is written.
`timescale 1ns / 1ps

module line_pixel_rasterizer_unit
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((2 * PIX_BITS + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_W-1:0]         s_tdata,   // start_x, start_y, end_x, end_y, zero pad
    input  logic                    s_tuser,   // command
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_W-1:0]        m_tdata,   // pixel_x, pixel_y, zero pad
    output logic                    m_tuser,   // pixel_valid
    output logic                    m_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CANVAS_BITS-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Canvas registers are plain flops and take a write in any cycle.
    assign cfg_ready = 1'b1;

    lpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lpr_datapath #(
        .COORD_BITS (COORD_BITS),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
